// ===== src/wbp_pkg.sv =====
// Shared types, constants and helpers of the wireframe box projector.
package wbp_pkg;

    localparam int SCREEN_W = 128;
    localparam int SCREEN_H = 64;

    localparam int W_POS  = 24;   // world position, Q15.8
    localparam int W_WX   = 25;   // corner x or z after the half size offset
    localparam int W_WY   = 25;   // corner or point height
    localparam int W_D    = 26;   // camera relative x, z and height
    localparam int W_TRIG = 16;   // Q1.14 cosine and sine
    localparam int TRIG_FRAC = 14;
    localparam int W_PROD = W_D + W_TRIG;        // rotation products
    localparam int W_C    = W_PROD + 1 - TRIG_FRAC; // camera space x and depth
    localparam int W_FOV  = 8;
    localparam int W_MX   = W_C + W_FOV + 1;
    localparam int W_MY   = W_D + W_FOV + 1;
    localparam int W_N    = 40;   // projection numerators
    localparam int W_DEN  = 16;   // visible depth fits the far register
    localparam int W_Q    = 12;   // quotient magnitude bits before overflow
    localparam int W_REM  = W_DEN + W_Q;
    localparam int W_SCR  = 12;   // screen coordinate
    localparam int W_CFG  = 24;
    localparam int W_IDX  = 3;
    localparam int W_U16  = 16;

    localparam int N_COL  = 7;    // corners held before the last one arrives
    localparam int N_EDGE = 12;

    typedef logic [2:0] t_cidx;

    localparam t_cidx EDGE_A [N_EDGE] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
                                          3'd6, 3'd7, 3'd0, 3'd1, 3'd2, 3'd3};
    localparam t_cidx EDGE_B [N_EDGE] = '{3'd1, 3'd2, 3'd3, 3'd0, 3'd5, 3'd6,
                                          3'd7, 3'd4, 3'd4, 3'd5, 3'd6, 3'd7};

    typedef enum logic [W_IDX-1:0] {
        REG_CAMERA_X, REG_CAMERA_Z, REG_COS_YAW, REG_SIN_NEG_YAW,
        REG_NEAR_DEPTH, REG_FAR_DEPTH, REG_FOV_SCALE, REG_EYE_HEIGHT
    } t_reg_idx;

    typedef struct packed {
        logic signed [W_POS-1:0]  cam_x;
        logic signed [W_POS-1:0]  cam_z;
        logic signed [W_TRIG-1:0] cos_yaw;
        logic signed [W_TRIG-1:0] sin_neg_yaw;
        logic [W_U16-1:0]         near_depth;
        logic [W_U16-1:0]         far_depth;
        logic [W_FOV-1:0]         fov_scale;
        logic [W_U16-1:0]         eye_height;
    } t_cfg;

    // sideband of one corner: last corner of its item, item is a point
    typedef struct packed {
        logic last;
        logic pix;
    } t_ctl;

    typedef struct packed {
        logic signed [W_SCR-1:0] x;
        logic signed [W_SCR-1:0] y;
    } t_xy;

    typedef struct packed {
        logic vis;
        t_xy  xy;
    } t_pt;

    localparam logic [W_Q-1:0] Q_MAX_POS = W_Q'(2 ** (W_SCR - 1) - 1);
    localparam logic [W_Q-1:0] Q_MAX_NEG = W_Q'(2 ** (W_SCR - 1));

    // sign and saturate a truncated quotient magnitude
    function automatic logic signed [W_SCR-1:0] sat_q(input logic [W_Q-1:0] q,
                                                      input logic ov,
                                                      input logic neg);
        logic signed [W_SCR-1:0] res;
        if (!neg) begin
            res = (ov || q > Q_MAX_POS) ? $signed(W_SCR'(Q_MAX_POS)) : $signed(W_SCR'(q));
        end else begin
            res = (ov || q > Q_MAX_NEG) ? $signed(W_SCR'(Q_MAX_NEG)) : $signed(W_SCR'(-q));
        end
        return res;
    endfunction

endpackage

// ===== src/wbp_req_if.sv =====
// Request channel: one box or point item.
interface wbp_req_if;
    import wbp_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    req_type;
    logic signed [W_POS-1:0] pos_x;
    logic signed [W_POS-1:0] pos_y;
    logic signed [W_POS-1:0] pos_z;
    logic [W_U16-1:0]        half_size;
    logic [W_U16-1:0]        box_height;

    modport source (output valid, req_type, pos_x, pos_y, pos_z, half_size, box_height,
                    input ready);
    modport sink   (input valid, req_type, pos_x, pos_y, pos_z, half_size, box_height,
                    output ready);
endinterface

// ===== src/wbp_res_if.sv =====
// Result channel: one segment or pixel item.
interface wbp_res_if;
    import wbp_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [W_SCR-1:0] start_x;
    logic signed [W_SCR-1:0] start_y;
    logic signed [W_SCR-1:0] end_x;
    logic signed [W_SCR-1:0] end_y;
    logic                    is_pixel;
    logic                    last_result;

    modport source (output valid, start_x, start_y, end_x, end_y, is_pixel, last_result,
                    input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, is_pixel, last_result,
                    output ready);
endinterface

// ===== src/wbp_corner_gen.sv =====
// Corner generator: holds one item and issues its eight corners or its point.
module wbp_corner_gen (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    wbp_req_if.sink                         i_req,
    output logic                            o_valid,
    output wbp_pkg::t_ctl                   o_ctl,
    output logic signed [wbp_pkg::W_WX-1:0] o_wx,
    output logic signed [wbp_pkg::W_WY-1:0] o_wy,
    output logic signed [wbp_pkg::W_WX-1:0] o_wz
);
    import wbp_pkg::*;

    logic                    r_act;
    logic [2:0]              r_cnt;
    logic                    r_type;
    logic signed [W_POS-1:0] r_px, r_py, r_pz;
    logic [W_U16-1:0]        r_half, r_height;

    logic                   s_last;
    logic                   s_take;
    logic signed [W_WX-1:0] s_half;

    assign s_last      = r_type || (r_cnt == 3'd7);
    assign i_req.ready = i_en && (!r_act || s_last);
    assign s_take      = i_req.valid && i_req.ready;
    assign s_half      = W_WX'($signed({1'b0, r_half}));

    always_comb begin
        o_valid   = r_act;
        o_ctl.last = s_last;
        o_ctl.pix  = r_type;
        if (r_type) begin
            o_wx = W_WX'(r_px);
            o_wy = W_WY'(r_py);
            o_wz = W_WX'(r_pz);
        end else begin
            o_wx = (r_cnt[1:0] == 2'd1 || r_cnt[1:0] == 2'd2) ? W_WX'(r_px) + s_half
                                                              : W_WX'(r_px) - s_half;
            o_wz = r_cnt[1] ? W_WX'(r_pz) + s_half : W_WX'(r_pz) - s_half;
            o_wy = r_cnt[2] ? W_WY'($signed({1'b0, r_height})) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_cnt <= '0;
        end else if (i_en) begin
            if (!r_act || s_last) begin
                r_act <= s_take;
                r_cnt <= '0;
            end else begin
                r_cnt <= r_cnt + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_type   <= i_req.req_type;
            r_px     <= i_req.pos_x;
            r_py     <= i_req.pos_y;
            r_pz     <= i_req.pos_z;
            r_half   <= i_req.half_size;
            r_height <= i_req.box_height;
        end
    end

endmodule

// ===== src/wbp_transform.sv =====
// Camera transform, depth clip and numerator stages (six register stages).
module wbp_transform (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  wbp_pkg::t_cfg                   i_cfg,
    input  logic                            i_valid,
    input  wbp_pkg::t_ctl                   i_ctl,
    input  logic signed [wbp_pkg::W_WX-1:0] i_wx,
    input  logic signed [wbp_pkg::W_WY-1:0] i_wy,
    input  logic signed [wbp_pkg::W_WX-1:0] i_wz,
    output logic                            o_valid,
    output wbp_pkg::t_ctl                   o_ctl,
    output logic                            o_vis,
    output logic [wbp_pkg::W_DEN-1:0]       o_den,
    output logic [wbp_pkg::W_N-1:0]         o_magx,
    output logic [wbp_pkg::W_N-1:0]         o_magy,
    output logic                            o_negx,
    output logic                            o_negy,
    output logic                            o_ovx,
    output logic                            o_ovy
);
    import wbp_pkg::*;

    localparam logic signed [W_N-1:0] HALF_W = W_N'(SCREEN_W / 2);
    localparam logic signed [W_N-1:0] HALF_H = W_N'(SCREEN_H / 2);

    logic [6:1] r_v;
    t_ctl       r_ctl [1:6];
    logic [6:4] r_vis;

    logic signed [W_D-1:0]    r1_dx, r1_dz, r1_cy;
    logic signed [W_PROD-1:0] r2_p1, r2_p2, r2_p3, r2_p4;
    logic signed [W_D-1:0]    r2_cy;
    logic signed [W_C-1:0]    r3_cx, r3_cz;
    logic signed [W_D-1:0]    r3_cy;
    logic signed [W_MX-1:0]   r4_mx;
    logic signed [W_MY-1:0]   r4_my;
    logic signed [W_C-1:0]    r4_cz;
    logic signed [W_N-1:0]    r5_nx, r5_ny;
    logic [W_DEN-1:0]         r5_den;

    logic signed [W_PROD:0]  s_sx, s_sz;
    logic [W_N-1:0]          s_magx, s_magy, s_lim;
    logic signed [W_FOV:0]   s_fov;
    logic                    s_vis;

    assign s_sx  = (W_PROD + 1)'(r2_p1) - (W_PROD + 1)'(r2_p2);
    assign s_sz  = (W_PROD + 1)'(r2_p3) + (W_PROD + 1)'(r2_p4);
    assign s_fov = $signed({1'b0, i_cfg.fov_scale});
    // nonpositive depth is never visible, whatever near holds
    assign s_vis = (r3_cz > 0) && (r3_cz >= $signed({1'b0, i_cfg.near_depth}))
                   && (r3_cz <= $signed({1'b0, i_cfg.far_depth}));
    assign s_magx = r5_nx[W_N-1] ? W_N'(-r5_nx) : W_N'(r5_nx);
    assign s_magy = r5_ny[W_N-1] ? W_N'(-r5_ny) : W_N'(r5_ny);
    assign s_lim  = W_N'({r5_den, {W_Q{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[5:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl[1] <= i_ctl;
            for (int k = 2; k <= 6; k++) r_ctl[k] <= r_ctl[k-1];
            // stage 1: camera relative position
            r1_dx <= W_D'(i_wx) - W_D'(i_cfg.cam_x);
            r1_dz <= W_D'(i_wz) - W_D'(i_cfg.cam_z);
            r1_cy <= W_D'(i_wy) - W_D'($signed({1'b0, i_cfg.eye_height}));
            // stage 2: rotation products
            r2_p1 <= r1_dx * i_cfg.cos_yaw;
            r2_p2 <= r1_dz * i_cfg.sin_neg_yaw;
            r2_p3 <= r1_dx * i_cfg.sin_neg_yaw;
            r2_p4 <= r1_dz * i_cfg.cos_yaw;
            r2_cy <= r1_cy;
            // stage 3: sums, floor shift back to Q.8
            r3_cx <= $signed(s_sx[W_PROD:TRIG_FRAC]);
            r3_cz <= $signed(s_sz[W_PROD:TRIG_FRAC]);
            r3_cy <= r2_cy;
            // stage 4: clip and scale
            r_vis[4] <= s_vis;
            r4_mx <= r3_cx * s_fov;
            r4_my <= r3_cy * s_fov;
            r4_cz <= r3_cz;
            // stage 5: numerators with screen center folded in
            r_vis[5] <= r_vis[4];
            r5_nx  <= W_N'(r4_cz) * HALF_W + W_N'(r4_mx);
            r5_ny  <= W_N'(r4_cz) * HALF_H - W_N'(r4_my);
            r5_den <= r4_cz[W_DEN-1:0];
            // stage 6: magnitude, sign, quotient overflow
            r_vis[6] <= r_vis[5];
            o_den  <= r5_den;
            o_magx <= s_magx;
            o_magy <= s_magy;
            o_negx <= r5_nx[W_N-1];
            o_negy <= r5_ny[W_N-1];
            o_ovx  <= s_magx >= s_lim;
            o_ovy  <= s_magy >= s_lim;
        end
    end

    assign o_valid = r_v[6];
    assign o_ctl   = r_ctl[6];
    assign o_vis   = r_vis[6];

endmodule

// ===== src/wbp_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, x and y lanes.
module wbp_divider (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  wbp_pkg::t_ctl             i_ctl,
    input  logic                      i_vis,
    input  logic [wbp_pkg::W_DEN-1:0] i_den,
    input  logic [wbp_pkg::W_N-1:0]   i_magx,
    input  logic [wbp_pkg::W_N-1:0]   i_magy,
    input  logic                      i_negx,
    input  logic                      i_negy,
    input  logic                      i_ovx,
    input  logic                      i_ovy,
    output logic                      o_valid,
    output wbp_pkg::t_ctl             o_ctl,
    output logic                      o_vis,
    output wbp_pkg::t_xy              o_pt
);
    import wbp_pkg::*;

    logic [W_Q-1:0]   r_v;
    t_ctl             r_ctl  [W_Q];
    logic             r_vis  [W_Q];
    logic [W_DEN-1:0] r_den  [W_Q];
    logic [W_REM-1:0] r_rx   [W_Q];
    logic [W_REM-1:0] r_ry   [W_Q];
    logic [W_Q-1:0]   r_qx   [W_Q];
    logic [W_Q-1:0]   r_qy   [W_Q];
    logic             r_sgnx [W_Q];
    logic             r_sgny [W_Q];
    logic             r_ovfx [W_Q];
    logic             r_ovfy [W_Q];
    logic             r_ov;

    for (genvar k = 0; k < W_Q; k++) begin : g_stage
        localparam int BIT = W_Q - 1 - k;
        logic             s_v;
        t_ctl             s_ctl;
        logic             s_vis, s_sgnx, s_sgny, s_ovfx, s_ovfy;
        logic [W_DEN-1:0] s_den;
        logic [W_REM-1:0] s_rx, s_ry, s_sh;
        logic [W_Q-1:0]   s_qx, s_qy;
        logic             s_tx, s_ty;

        if (k == 0) begin : g_first
            assign s_v    = i_valid;
            assign s_ctl  = i_ctl;
            assign s_vis  = i_vis;
            assign s_den  = i_den;
            assign s_rx   = i_magx[W_REM-1:0];
            assign s_ry   = i_magy[W_REM-1:0];
            assign s_qx   = '0;
            assign s_qy   = '0;
            assign s_sgnx = i_negx;
            assign s_sgny = i_negy;
            assign s_ovfx = i_ovx;
            assign s_ovfy = i_ovy;
        end else begin : g_next
            assign s_v    = r_v[k-1];
            assign s_ctl  = r_ctl[k-1];
            assign s_vis  = r_vis[k-1];
            assign s_den  = r_den[k-1];
            assign s_rx   = r_rx[k-1];
            assign s_ry   = r_ry[k-1];
            assign s_qx   = r_qx[k-1];
            assign s_qy   = r_qy[k-1];
            assign s_sgnx = r_sgnx[k-1];
            assign s_sgny = r_sgny[k-1];
            assign s_ovfx = r_ovfx[k-1];
            assign s_ovfy = r_ovfy[k-1];
        end

        assign s_sh = W_REM'(s_den) << BIT;
        assign s_tx = s_rx >= s_sh;
        assign s_ty = s_ry >= s_sh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= s_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ctl[k]  <= s_ctl;
                r_vis[k]  <= s_vis;
                r_den[k]  <= s_den;
                r_sgnx[k] <= s_sgnx;
                r_sgny[k] <= s_sgny;
                r_ovfx[k] <= s_ovfx;
                r_ovfy[k] <= s_ovfy;
                r_rx[k]   <= s_tx ? s_rx - s_sh : s_rx;
                r_ry[k]   <= s_ty ? s_ry - s_sh : s_ry;
                r_qx[k]   <= s_qx | (W_Q'(s_tx) << BIT);
                r_qy[k]   <= s_qy | (W_Q'(s_ty) << BIT);
            end
        end
    end

    // output stage: sign and saturate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_v[W_Q-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ctl  <= r_ctl[W_Q-1];
            o_vis  <= r_vis[W_Q-1];
            o_pt.x <= sat_q(r_qx[W_Q-1], r_ovfx[W_Q-1], r_sgnx[W_Q-1]);
            o_pt.y <= sat_q(r_qy[W_Q-1], r_ovfy[W_Q-1], r_sgny[W_Q-1]);
        end
    end

    assign o_valid = r_ov;

endmodule

// ===== src/wbp_edge_emit.sv =====
// Corner collector, edge list and output register.
module wbp_edge_emit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  wbp_pkg::t_ctl i_ctl,
    input  logic          i_vis,
    input  wbp_pkg::t_xy  i_pt,
    output logic          o_en,
    wbp_res_if.source     o_res
);
    import wbp_pkg::*;

    t_pt               r_col [N_COL];
    logic [N_EDGE-1:0] r_seg_v;
    t_xy               r_seg_a [N_EDGE];
    t_xy               r_seg_b [N_EDGE];
    logic              r_pix;

    logic r_o_valid, r_o_pix, r_o_last;
    t_xy  r_o_a, r_o_b;

    t_pt  s_cor [N_COL + 1];
    logic s_take, s_adv, s_free, s_load;

    always_comb begin
        for (int i = 0; i < N_COL; i++) s_cor[i] = r_col[i];
        s_cor[N_COL] = {i_vis, i_pt};
    end

    assign s_take = !r_o_valid || o_res.ready;
    assign s_adv  = !r_seg_v[0] || s_take;
    // buffer empty once this cycle's shift is done
    assign s_free = s_adv ? ~|r_seg_v[N_EDGE-1:1] : ~|r_seg_v;
    assign s_load = i_valid && i_ctl.last && s_free;
    assign o_en   = !(i_valid && i_ctl.last && !s_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_seg_v   <= '0;
        end else begin
            // output slot frees up and takes the head of the edge list
            if (s_take) r_o_valid <= r_seg_v[0];
            if (s_load) begin
                if (i_ctl.pix) begin
                    r_seg_v <= N_EDGE'(i_vis);
                end else begin
                    for (int e = 0; e < N_EDGE; e++)
                        r_seg_v[e] <= s_cor[EDGE_A[e]].vis & s_cor[EDGE_B[e]].vis;
                end
            end else if (s_adv) begin
                r_seg_v <= {1'b0, r_seg_v[N_EDGE-1:1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv && r_seg_v[0]) begin
            r_o_a    <= r_seg_a[0];
            r_o_b    <= r_seg_b[0];
            r_o_pix  <= r_pix;
            r_o_last <= ~|r_seg_v[N_EDGE-1:1];
        end
        if (s_load) begin
            r_pix <= i_ctl.pix;
            if (i_ctl.pix) begin
                r_seg_a[0] <= i_pt;
                r_seg_b[0] <= i_pt;
            end else begin
                for (int e = 0; e < N_EDGE; e++) begin
                    r_seg_a[e] <= s_cor[EDGE_A[e]].xy;
                    r_seg_b[e] <= s_cor[EDGE_B[e]].xy;
                end
            end
        end else if (s_adv) begin
            for (int e = 0; e < N_EDGE - 1; e++) begin
                r_seg_a[e] <= r_seg_a[e+1];
                r_seg_b[e] <= r_seg_b[e+1];
            end
        end
        if (o_en && i_valid) begin
            r_col[N_COL-1] <= {i_vis, i_pt};
            for (int i = 0; i < N_COL - 1; i++) r_col[i] <= r_col[i+1];
        end
    end

    assign o_res.valid       = r_o_valid;
    assign o_res.start_x     = r_o_a.x;
    assign o_res.start_y     = r_o_a.y;
    assign o_res.end_x       = r_o_b.x;
    assign o_res.end_y       = r_o_b.y;
    assign o_res.is_pixel    = r_o_pix;
    assign o_res.last_result = r_o_last;

`ifndef SYNTHESIS
    a_stall_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_en |-> (i_valid && i_ctl.last))
        else $error("pipeline held without a finished item waiting");
    a_pixel_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pix |-> ~|r_seg_v[N_EDGE-1:1])
        else $error("pixel item holds more than one result");
    a_seg_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !o_res.ready && r_seg_v[0]) |=> $stable(r_seg_v))
        else $error("edge list moved while output stalled");
`endif

endmodule

// ===== src/wireframe_box_projector_unit.sv =====
// Top level of the wireframe box projector.
//
// i_req takes one item per handshake: a ground box (req_type 0) or a point
// (req_type 1). o_res gives its results: up to twelve segments of a box, one per
// edge in fixed edge order, or one pixel; last_result marks the final one. An item
// with nothing visible gives no result at all.
// A box issues its eight corners from the corner generator and up to twelve
// segments wait in the edge list; a point issues one. A new item is taken while
// earlier corners are still in the pipeline and results still wait.
// From accept to result the path is the corner generator, six transform
// stages, twelve divider stages (one quotient bit each) and a saturate stage.
// When o_res stalls, the edge list holds, and once the next finished item
// cannot hand off its corners the whole pipeline freezes; nothing is lost.
// Registers are written on i_cfg_we with index i_cfg_idx; write only while idle.
// Synchronous reset loads the default camera and clears all valid state.
module wireframe_box_projector_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [wbp_pkg::W_IDX-1:0] i_cfg_idx,
    input  logic [wbp_pkg::W_CFG-1:0] i_cfg_data,
    wbp_req_if.sink                   i_req,
    wbp_res_if.source                 o_res
);
    import wbp_pkg::*;

    t_cfg r_cfg;

    // pipeline advance, low when a finished item waits on a busy edge list
    logic s_en;

    logic                   g_valid;
    t_ctl                   g_ctl;
    logic signed [W_WX-1:0] g_wx, g_wz;
    logic signed [W_WY-1:0] g_wy;

    logic             t_valid, t_vis, t_negx, t_negy, t_ovx, t_ovy;
    t_ctl             t_ctl_o;
    logic [W_DEN-1:0] t_den;
    logic [W_N-1:0]   t_magx, t_magy;

    logic d_valid, d_vis;
    t_ctl d_ctl;
    t_xy  d_pt;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cam_x       <= '0;
            r_cfg.cam_z       <= -24'sd2048;
            r_cfg.cos_yaw     <= 16'sd16384;
            r_cfg.sin_neg_yaw <= '0;
            r_cfg.near_depth  <= 16'd128;
            r_cfg.far_depth   <= 16'd15360;
            r_cfg.fov_scale   <= 8'd80;
            r_cfg.eye_height  <= 16'd256;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_CAMERA_X:    r_cfg.cam_x       <= i_cfg_data;
                REG_CAMERA_Z:    r_cfg.cam_z       <= i_cfg_data;
                REG_COS_YAW:     r_cfg.cos_yaw     <= i_cfg_data[W_TRIG-1:0];
                REG_SIN_NEG_YAW: r_cfg.sin_neg_yaw <= i_cfg_data[W_TRIG-1:0];
                REG_NEAR_DEPTH:  r_cfg.near_depth  <= i_cfg_data[W_U16-1:0];
                REG_FAR_DEPTH:   r_cfg.far_depth   <= i_cfg_data[W_U16-1:0];
                REG_FOV_SCALE:   r_cfg.fov_scale   <= i_cfg_data[W_FOV-1:0];
                REG_EYE_HEIGHT:  r_cfg.eye_height  <= i_cfg_data[W_U16-1:0];
                default: ;
            endcase
        end
    end

    wbp_corner_gen u_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s_en),
        .i_req   (i_req),
        .o_valid (g_valid),
        .o_ctl   (g_ctl),
        .o_wx    (g_wx),
        .o_wy    (g_wy),
        .o_wz    (g_wz)
    );

    wbp_transform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s_en),
        .i_cfg   (r_cfg),
        .i_valid (g_valid),
        .i_ctl   (g_ctl),
        .i_wx    (g_wx),
        .i_wy    (g_wy),
        .i_wz    (g_wz),
        .o_valid (t_valid),
        .o_ctl   (t_ctl_o),
        .o_vis   (t_vis),
        .o_den   (t_den),
        .o_magx  (t_magx),
        .o_magy  (t_magy),
        .o_negx  (t_negx),
        .o_negy  (t_negy),
        .o_ovx   (t_ovx),
        .o_ovy   (t_ovy)
    );

    wbp_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s_en),
        .i_valid (t_valid),
        .i_ctl   (t_ctl_o),
        .i_vis   (t_vis),
        .i_den   (t_den),
        .i_magx  (t_magx),
        .i_magy  (t_magy),
        .i_negx  (t_negx),
        .i_negy  (t_negy),
        .i_ovx   (t_ovx),
        .i_ovy   (t_ovy),
        .o_valid (d_valid),
        .o_ctl   (d_ctl),
        .o_vis   (d_vis),
        .o_pt    (d_pt)
    );

    wbp_edge_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d_valid),
        .i_ctl   (d_ctl),
        .i_vis   (d_vis),
        .i_pt    (d_pt),
        .o_en    (s_en),
        .o_res   (o_res)
    );

endmodule

// ===== sim/tb_wireframe_box_projector_unit.sv =====
// Self-checking testbench of the wireframe box projector: random and directed items.
`timescale 1ns / 100ps

module tb_wireframe_box_projector_unit;
    import wbp_pkg::*;

    // one item offered on the request channel
    typedef struct {
        logic                    req_type;
        logic signed [W_POS-1:0] pos_x;
        logic signed [W_POS-1:0] pos_y;
        logic signed [W_POS-1:0] pos_z;
        logic [W_U16-1:0]        half_size;
        logic [W_U16-1:0]        box_height;
    } t_shape_req;

    // one segment or pixel on the result channel
    typedef struct {
        logic signed [W_SCR-1:0] start_x;
        logic signed [W_SCR-1:0] start_y;
        logic signed [W_SCR-1:0] end_x;
        logic signed [W_SCR-1:0] end_y;
        logic                    is_pixel;
        logic                    last_result;
    } t_seg;

    localparam logic REQ_BOX   = 1'b0;
    localparam logic REQ_POINT = 1'b1;

    // Holds a copy of the camera registers, predicts the segments of every
    // accepted item and checks the results against them in order.
    class projection_scoreboard;
        longint cam_x, cam_z, cos_q, sin_q, near_d, far_d, fov, eye;
        t_seg   segs_due[$];
        int     n_err;
        int     edge_a[N_EDGE] = '{0, 1, 2, 3, 4, 5, 6, 7, 0, 1, 2, 3};
        int     edge_b[N_EDGE] = '{1, 2, 3, 0, 5, 6, 7, 4, 4, 5, 6, 7};

        function new();
            cam_x  = 0;
            cam_z  = -2048;
            cos_q  = 16384;
            sin_q  = 0;
            near_d = 128;
            far_d  = 15360;
            fov    = 80;
            eye    = 256;
            n_err  = 0;
        endfunction

        function void set_reg(t_reg_idx r, logic [W_CFG-1:0] v);
            case (r)
                REG_CAMERA_X:    cam_x  = longint'($signed(v[23:0]));
                REG_CAMERA_Z:    cam_z  = longint'($signed(v[23:0]));
                REG_COS_YAW:     cos_q  = longint'($signed(v[15:0]));
                REG_SIN_NEG_YAW: sin_q  = longint'($signed(v[15:0]));
                REG_NEAR_DEPTH:  near_d = longint'(v[15:0]);
                REG_FAR_DEPTH:   far_d  = longint'(v[15:0]);
                REG_FOV_SCALE:   fov    = longint'(v[7:0]);
                REG_EYE_HEIGHT:  eye    = longint'(v[15:0]);
                default: ;
            endcase
        endfunction

        function longint clamp12(longint v);
            if (v > 2047) return 2047;
            if (v < -2048) return -2048;
            return v;
        endfunction

        // camera transform and perspective divide; 0 when out of depth range
        function bit to_screen(longint wx, longint wy, longint wz,
                               output longint sx, output longint sy);
            longint dx, dz, cx, cz, cy;
            dx = wx - cam_x;
            dz = wz - cam_z;
            cx = (dx * cos_q - dz * sin_q) >>> TRIG_FRAC;   // floor
            cz = (dx * sin_q + dz * cos_q) >>> TRIG_FRAC;
            cy = wy - eye;
            sx = 0;
            sy = 0;
            if (cz <= 0 || cz < near_d || cz > far_d) return 1'b0;
            sx = clamp12(((SCREEN_W / 2) * cz + cx * fov) / cz);  // truncates
            sy = clamp12(((SCREEN_H / 2) * cz - cy * fov) / cz);
            return 1'b1;
        endfunction

        function void note_item(t_shape_req r);
            longint px, py, pz, half, hgt, sx, sy, wx, wz;
            longint vx[8], vy[8];
            bit     vis[8];
            t_seg   s;
            int     q, n0;
            px   = longint'(r.pos_x);
            py   = longint'(r.pos_y);
            pz   = longint'(r.pos_z);
            half = longint'(r.half_size);
            hgt  = longint'(r.box_height);
            n0   = segs_due.size();
            if (r.req_type == REQ_POINT) begin
                if (to_screen(px, py, pz, sx, sy)) begin
                    s = '{W_SCR'(sx), W_SCR'(sy), W_SCR'(sx), W_SCR'(sy), 1'b1, 1'b0};
                    segs_due.push_back(s);
                end
            end else begin
                // corners 0..3 on the ground, 4..7 on top, ring order in x/z
                for (int i = 0; i < 8; i++) begin
                    q  = i & 3;
                    wx = (q == 1 || q == 2) ? px + half : px - half;
                    wz = (q >= 2) ? pz + half : pz - half;
                    vis[i] = to_screen(wx, (i >= 4) ? hgt : 0, wz, vx[i], vy[i]);
                end
                for (int e = 0; e < N_EDGE; e++) begin
                    if (vis[edge_a[e]] && vis[edge_b[e]]) begin
                        s = '{W_SCR'(vx[edge_a[e]]), W_SCR'(vy[edge_a[e]]),
                              W_SCR'(vx[edge_b[e]]), W_SCR'(vy[edge_b[e]]), 1'b0, 1'b0};
                        segs_due.push_back(s);
                    end
                end
            end
            if (segs_due.size() > n0) segs_due[segs_due.size() - 1].last_result = 1'b1;
        endfunction

        function void check_result(t_seg got);
            t_seg want;
            if (segs_due.size() == 0) begin
                $error("unexpected result start=(%0d,%0d)", got.start_x, got.start_y);
                n_err++;
                return;
            end
            want = segs_due.pop_front();
            if (got.start_x !== want.start_x) begin
                $error("start_x expected %0d got %0d", want.start_x, got.start_x);
                n_err++;
            end
            if (got.start_y !== want.start_y) begin
                $error("start_y expected %0d got %0d", want.start_y, got.start_y);
                n_err++;
            end
            if (got.end_x !== want.end_x) begin
                $error("end_x expected %0d got %0d", want.end_x, got.end_x);
                n_err++;
            end
            if (got.end_y !== want.end_y) begin
                $error("end_y expected %0d got %0d", want.end_y, got.end_y);
                n_err++;
            end
            if (got.is_pixel !== want.is_pixel) begin
                $error("is_pixel expected %0d got %0d", want.is_pixel, got.is_pixel);
                n_err++;
            end
            if (got.last_result !== want.last_result) begin
                $error("last_result expected %0d got %0d", want.last_result,
                       got.last_result);
                n_err++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [W_IDX-1:0] i_cfg_idx;
    logic [W_CFG-1:0] i_cfg_data;

    wbp_req_if req_ch ();
    wbp_res_if res_ch ();

    wireframe_box_projector_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch.sink),
        .o_res      (res_ch.source)
    );

    projection_scoreboard sb = new();

    bit no_gaps;      // sender offers back to back
    bit hold_req;     // receiver should stall for a long stretch
    bit rx_fast;      // receiver never stalls

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // give up well past the slowest legal run
    initial begin
        #5000000;
        $display("wireframe_box_projector_unit test failed");
        $finish;
    end

    // accepted items feed the predictor; accepted results get checked
    always @(posedge i_clk) begin
        if (i_rst_n && req_ch.valid && req_ch.ready)
            sb.note_item('{req_ch.req_type, req_ch.pos_x, req_ch.pos_y, req_ch.pos_z,
                           req_ch.half_size, req_ch.box_height});
        if (i_rst_n && res_ch.valid && res_ch.ready)
            sb.check_result('{res_ch.start_x, res_ch.start_y, res_ch.end_x, res_ch.end_y,
                              res_ch.is_pixel, res_ch.last_result});
    end

    // result side: random stall per result, plus one long hold-off on request
    initial begin
        int stall;
        res_ch.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                res_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_req = 1'b0;
            end
            stall = rx_fast ? 0 : ($urandom_range(0, 1) ? 0 : $urandom_range(1, 11));
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_ch.valid && !hold_req) @(posedge i_clk);
        end
    end

    task automatic send_item(t_shape_req r);
        int gap;
        gap = no_gaps ? 0 : ($urandom_range(0, 1) ? 0 : $urandom_range(1, 11));
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.req_type   <= r.req_type;
        req_ch.pos_x      <= r.pos_x;
        req_ch.pos_y      <= r.pos_y;
        req_ch.pos_z      <= r.pos_z;
        req_ch.half_size  <= r.half_size;
        req_ch.box_height <= r.box_height;
        req_ch.valid      <= 1'b1;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    // stop offering, wait for every predicted result, then let the pipe empty
    task automatic drain();
        int guard;
        guard = 0;
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.segs_due.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        if (sb.segs_due.size() != 0) begin
            $error("%0d results never arrived", sb.segs_due.size());
            sb.n_err++;
            sb.segs_due.delete();
        end
        repeat (40) @(posedge i_clk);   // boxes with nothing visible still in flight
    endtask

    task automatic write_reg(t_reg_idx r, logic [W_CFG-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= r;
        i_cfg_data <= v;
        sb.set_reg(r, v);
        @(posedge i_clk);
    endtask

    task automatic set_camera(logic [W_CFG-1:0] cx, logic [W_CFG-1:0] cz,
                              logic [W_CFG-1:0] cs, logic [W_CFG-1:0] sn,
                              logic [W_CFG-1:0] nr, logic [W_CFG-1:0] fr,
                              logic [W_CFG-1:0] fv, logic [W_CFG-1:0] ey);
        write_reg(REG_CAMERA_X, cx);
        write_reg(REG_CAMERA_Z, cz);
        write_reg(REG_COS_YAW, cs);
        write_reg(REG_SIN_NEG_YAW, sn);
        write_reg(REG_NEAR_DEPTH, nr);
        write_reg(REG_FAR_DEPTH, fr);
        write_reg(REG_FOV_SCALE, fv);
        write_reg(REG_EYE_HEIGHT, ey);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_shape_req mk(logic t, int x, int y, int z, int h, int bh);
        t_shape_req r;
        r = '{t, W_POS'(x), W_POS'(y), W_POS'(z), W_U16'(h), W_U16'(bh)};
        return r;
    endfunction

    // mostly shapes placed in front of the camera, a quarter pure noise
    function automatic t_shape_req rand_shape();
        t_shape_req r;
        if ($urandom_range(0, 3) == 0) begin
            r = '{$urandom_range(0, 1), W_POS'($urandom), W_POS'($urandom),
                  W_POS'($urandom), W_U16'($urandom), W_U16'($urandom)};
        end else begin
            r.req_type   = $urandom_range(0, 2) == 0 ? REQ_POINT : REQ_BOX;
            r.pos_x      = W_POS'(sb.cam_x + $urandom_range(0, 6144) - 3072);
            r.pos_z      = W_POS'(sb.cam_z + $urandom_range(0, 12000) - 1000);
            r.pos_y      = W_POS'(sb.eye + $urandom_range(0, 2048) - 1024);
            r.half_size  = W_U16'($urandom_range(0, 768));
            r.box_height = W_U16'($urandom_range(0, 1024));
        end
        return r;
    endfunction

    task automatic send_random(int n);
        repeat (n) send_item(rand_shape());
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = '0;
        i_cfg_data        = '0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_BOX;
        req_ch.pos_x      = '0;
        req_ch.pos_y      = '0;
        req_ch.pos_z      = '0;
        req_ch.half_size  = '0;
        req_ch.box_height = '0;
        no_gaps  = 1'b0;
        hold_req = 1'b0;
        rx_fast  = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset camera at z=-8 looking down +z
        send_item(mk(REQ_POINT, 0, 256, 0, 0, 0));              // screen center
        send_item(mk(REQ_POINT, 0, 0, -4096, 0, 0));            // behind camera
        send_item(mk(REQ_POINT, 100, 300, -1920, 0, 0));        // depth at near
        send_item(mk(REQ_POINT, 0, 0, -1921, 0, 0));            // just short of near
        send_item(mk(REQ_POINT, -500, 900, 13312, 0, 0));       // depth at far
        send_item(mk(REQ_POINT, 0, 0, 13313, 0, 0));            // just past far
        send_item(mk(REQ_POINT, 8388607, 8388607, -1900, 0, 0));   // saturate high
        send_item(mk(REQ_POINT, -8388608, -8388608, -1900, 0, 0)); // saturate low
        send_item(mk(REQ_POINT, 0, 0, -2048, 0, 0));            // zero depth
        send_item(mk(REQ_BOX, 0, 0, 1280, 256, 512));           // twelve segments, every edge visible
        send_item(mk(REQ_BOX, 0, 0, -1900, 256, 512));          // straddles near
        send_item(mk(REQ_BOX, 0, 0, 13200, 256, 512));          // straddles far
        send_item(mk(REQ_BOX, 0, 0, 2000, 0, 0));               // degenerate
        send_item(mk(REQ_BOX, 0, 0, 0, 65535, 65535));          // largest size
        send_item(mk(REQ_BOX, 0, 0, -8000, 256, 256));          // nothing visible
        send_item(mk(REQ_BOX, 8388607, 0, 8388607, 65535, 100));
        send_item(mk(REQ_BOX, -8388608, 0, -8388608, 65535, 100));
        send_item(mk(REQ_BOX, 700, 0, 1500, 128, 65535));
        send_random(10);
        drain();

        // extremes of every register
        set_camera(24'h800000, 24'h7FFFFF, -16384, 16384, 1, 65535, 255, 65535);
        send_item(mk(REQ_POINT, -8388608, 0, 8388607, 0, 0));
        send_random(10);
        drain();
        set_camera(24'h7FFFFF, 24'h800000, 16384, -16384, 65535, 1, 1, 0);
        send_random(6);                                          // near beyond far
        drain();

        // 45 degree yaw; long receiver hold-off while the sender keeps going
        set_camera(512, -1024, 11585, 11585, 64, 8000, 1, 0);
        rx_fast  = 1'b0;
        no_gaps  = 1'b1;
        hold_req = 1'b1;
        repeat (25) send_item(mk(REQ_BOX, 512 + $urandom_range(0, 512), 0,
                                 -1024 + $urandom_range(512, 3000), 200, 300));
        no_gaps = 1'b0;
        send_random(10);
        drain();

        // raw 24-bit data on every register, upper bits unused for narrow ones
        set_camera($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom);
        send_random(10);
        drain();

        // back to a plain camera, fast, then with random gaps and stalls
        set_camera(0, -2048, 16384, 0, 128, 15360, 80, 256);
        rx_fast = 1'b1;
        no_gaps = 1'b1;
        send_random(10);
        rx_fast = 1'b0;
        no_gaps = 1'b0;
        send_random(10);
        drain();

        if (sb.n_err == 0) begin
            $display("wireframe_box_projector_unit test passed");
        end else begin
            $display("wireframe_box_projector_unit test failed");
        end
        $finish;
    end

endmodule
